/* hw/rtl/mfek_pkg.sv */
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared constants for the max-flow core: field widths, register indexes,
// default node count.
// ----------------------------------------------------------------------------
package mfek_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int IDX_W         = 6;
  localparam int CAP_W         = 31;
  localparam int RES_W         = 32;
  localparam int FLOW_W        = 40;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINK   = 1'd1;

endpackage

/* hw/rtl/max_flow_edmonds_karp_core.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_core
// Edge loader and Edmonds-Karp max-flow engine over a residual matrix in RAM.
// ----------------------------------------------------------------------------
// Edges load at one item per cycle while the core is in its load state (in_ready
// high); no result except on the last edge. Last edge: each round starts a BFS
// that dequeues nodes and scans each one's neighbours in order, with one last pop
// when the queue runs dry; the path is walked back once for the minimum and once
// more for the update; the result loads (held while the previous one waits); then the
// matrix clear of every word. After reset the same clear runs before any item.
module max_flow_edmonds_karp_core #(
  parameter int MAX_NODES = mfek_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mfek_pkg::IDX_W-1:0]     in_from_node,
  input  logic [mfek_pkg::IDX_W-1:0]     in_to_node,
  input  logic [mfek_pkg::CAP_W-1:0]     in_edge_capacity,
  input  logic                           in_last_edge,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mfek_pkg::FLOW_W-1:0]    out_max_flow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfek_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfek_pkg::IDX_W-1:0]     cfg_data
);
  import mfek_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int MAW = 2 * NW;
  localparam int NDP = 1 << NW;
  localparam logic [NW-1:0] LAST_V = NW'(MAX_NODES - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_POPW = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_AP   = 4'd6;
  localparam logic [3:0] S_APW  = 4'd7;
  localparam logic [3:0] S_AM   = 4'd8;
  localparam logic [3:0] S_BP   = 4'd9;
  localparam logic [3:0] S_BPW  = 4'd10;
  localparam logic [3:0] S_BF   = 4'd11;
  localparam logic [3:0] S_BB   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]         state_r;
  logic [IDX_W-1:0]   src_r, snk_r;
  logic [FLOW_W-1:0]  flow_r;
  logic [FLOW_W-1:0]  out_flow_r;
  logic               out_valid_r;
  logic [MAW-1:0]     clr_cnt_r;
  logic [NW:0]        head_r, tail_r;
  logic [NW-1:0]      cur_r, chk_v_r, v_r, walk_v_r, u_r;
  logic [MAX_NODES-1:0] vis_r;
  logic [RES_W-1:0]   f_r;

  logic               m_we;
  logic [MAW-1:0]     m_waddr, m_raddr;
  logic [RES_W-1:0]   m_wdata, m_rdata;
  logic               q_we;
  logic [NW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;
  logic               p_we;
  logic [NW-1:0]      p_waddr, p_raddr, p_wdata, p_rdata;

  logic [NW-1:0]      src_n, snk_n;
  logic               ends_ok, edge_ok, in_acc, hit, q_room;
  logic [RES_W:0]     bsum;
  logic [FLOW_W:0]    fsum;
  logic [RES_W-1:0]   back_sat;
  logic [FLOW_W-1:0]  flow_sat;

  assign src_n    = NW'(src_r);
  assign snk_n    = NW'(snk_r);
  assign ends_ok  = (32'(src_r) < MAX_NODES) && (32'(snk_r) < MAX_NODES) && (src_r != snk_r);
  assign edge_ok  = (32'(in_from_node) < MAX_NODES) && (32'(in_to_node) < MAX_NODES);
  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_max_flow = out_flow_r;

  assign hit      = !vis_r[chk_v_r] && (m_rdata != '0);
  assign q_room   = (32'(tail_r) < MAX_NODES);
  assign bsum     = {1'b0, m_rdata} + {1'b0, f_r};
  assign back_sat = bsum[RES_W] ? '1 : bsum[RES_W-1:0];
  assign fsum     = {1'b0, flow_r} + (FLOW_W+1)'(f_r);
  assign flow_sat = fsum[FLOW_W] ? '1 : fsum[FLOW_W-1:0];

  always_comb begin
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = '0;
    m_raddr = '0;
    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_raddr = head_r[NW-1:0];
    p_we    = 1'b0;
    p_waddr = chk_v_r;
    p_wdata = cur_r;
    p_raddr = walk_v_r;
    case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt_r;
      end
      S_LOAD: begin
        m_we    = in_acc && edge_ok;
        m_waddr = {NW'(in_from_node), NW'(in_to_node)};
        m_wdata = RES_W'(in_edge_capacity);
      end
      S_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = src_n;
      end
      S_POPW: m_raddr = {q_rdata, {NW{1'b0}}};
      S_SCAN: begin
        m_raddr = {cur_r, v_r};
        p_we    = hit;
        q_we    = hit && q_room;
        q_waddr = tail_r[NW-1:0];
        q_wdata = chk_v_r;
      end
      S_APW:  m_raddr = {p_rdata, walk_v_r};
      S_BPW:  m_raddr = {p_rdata, walk_v_r};
      S_BF: begin
        m_we    = 1'b1;
        m_waddr = {u_r, walk_v_r};
        m_wdata = m_rdata - f_r;
        m_raddr = {walk_v_r, u_r};
      end
      S_BB: begin
        m_we    = 1'b1;
        m_waddr = {walk_v_r, u_r};
        m_wdata = back_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      src_r       <= '0;
      snk_r       <= IDX_W'(1);
      flow_r      <= '0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SOURCE: src_r <= cfg_data;
          REG_SINK:   snk_r <= cfg_data;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            flow_r  <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (in_acc && in_last_edge) begin
            state_r <= ends_ok ? S_INIT : S_DONE;
          end
        end
        S_INIT: begin
          vis_r         <= MAX_NODES'(1) << src_n;
          head_r        <= '0;
          tail_r        <= (NW+1)'(1);
          state_r       <= S_POP;
        end
        S_POP: begin
          if (head_r == tail_r) begin
            state_r <= S_DONE;
          end else begin
            head_r  <= head_r + 1'b1;
            state_r <= S_POPW;
          end
        end
        S_POPW: begin
          cur_r   <= q_rdata;
          chk_v_r <= '0;
          v_r     <= NW'(1);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            vis_r[chk_v_r] <= 1'b1;
            if (q_room) begin
              tail_r <= tail_r + 1'b1;
            end
          end
          if (hit && chk_v_r == snk_n) begin
            walk_v_r <= snk_n;
            f_r      <= '1;
            state_r  <= S_AP;
          end else if (chk_v_r == LAST_V) begin
            state_r <= S_POP;
          end else begin
            chk_v_r <= v_r;
            v_r     <= v_r + 1'b1;
          end
        end
        S_AP:  state_r <= S_APW;
        S_APW: begin
          u_r     <= p_rdata;
          state_r <= S_AM;
        end
        S_AM: begin
          if (m_rdata < f_r) begin
            f_r <= m_rdata;
          end
          if (u_r == src_n) begin
            walk_v_r <= snk_n;
            state_r  <= S_BP;
          end else begin
            walk_v_r <= u_r;
            state_r  <= S_AP;
          end
        end
        S_BP:  state_r <= S_BPW;
        S_BPW: begin
          u_r     <= p_rdata;
          state_r <= S_BF;
        end
        S_BF:  state_r <= S_BB;
        S_BB: begin
          walk_v_r <= u_r;
          if (u_r == src_n) begin
            flow_r  <= flow_sat;
            state_r <= S_INIT;
          end else begin
            state_r <= S_BP;
          end
        end
        S_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_flow_r  <= flow_r;
            clr_cnt_r   <= '0;
            state_r     <= S_CLR;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  mfek_ram #(.WIDTH(RES_W), .DEPTH(NDP * NDP)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  mfek_ram #(.WIDTH(NW), .DEPTH(NDP)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  mfek_ram #(.WIDTH(NW), .DEPTH(NDP)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // path residuals were found nonzero and are untouched until the update
  a_path_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AM |-> m_rdata != '0)
    else $error("zero residual on augmenting path");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP || state_r == S_SCAN) |-> head_r <= tail_r)
    else $error("queue head passed tail");

  a_round_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BB && u_r == src_n) |=> state_r == S_INIT)
    else $error("augment did not restart search");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_CLR))
    else $error("result not loaded");

endmodule

/* hw/rtl/mfek_ram.sv */
// ----------------------------------------------------------------------------
// mfek_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mfek_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives graphs of edges into the max-flow core and checks each reported
// flow against a behavioural Edmonds-Karp solver or a fixed value.
// ----------------------------------------------------------------------------
module tb;
  import mfek_pkg::*;

  localparam int NN        = 64;
  localparam logic [30:0] CAP_INF = 31'h7FFF_FFFF;
  localparam int CLEAR_CYC = 4400;

  typedef struct {
    logic [IDX_W-1:0] from_n;
    logic [IDX_W-1:0] to_n;
    logic [CAP_W-1:0] cap;
    logic             last;
    logic             typed;
    logic [FLOW_W-1:0] flow;
  } edge_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_from_node = '0;
  logic [IDX_W-1:0] in_to_node = '0;
  logic [CAP_W-1:0] in_edge_capacity = '0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FLOW_W-1:0] out_max_flow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0] cfg_data = '0;

  max_flow_edmonds_karp_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // solver state
  logic [31:0] resid [NN][NN];
  logic [IDX_W-1:0] src_node = 0, snk_node = 1;
  logic [FLOW_W-1:0] flow_expect_q [$];

  int errors = 0, graphs = 0, items = 0, typed_checks = 0;
  bit quiet = 0, hold_req = 0;

  function automatic logic [FLOW_W-1:0] solve_flow();
    bit        seen [NN];
    int        par [NN];
    int        fifo [NN];
    int        head, tail, cur, v;
    bit        found;
    logic [31:0] f, back;
    logic [40:0] total;
    total = 0;
    if (src_node == snk_node) return '0;
    forever begin
      foreach (seen[i]) begin seen[i] = 0; par[i] = 0; end
      head = 0; tail = 0; found = 0;
      seen[src_node] = 1;
      fifo[tail++] = src_node;
      while (head < tail && !found) begin
        cur = fifo[head++];
        for (v = 0; v < NN && !found; v++) begin
          if (!seen[v] && resid[cur][v] != 0) begin
            seen[v] = 1;
            par[v] = cur;
            if (tail < NN) fifo[tail++] = v;
            if (v == snk_node) found = 1;
          end
        end
      end
      if (!found) break;
      f = 32'hFFFF_FFFF;
      for (v = snk_node; v != src_node; v = par[v])
        if (resid[par[v]][v] < f) f = resid[par[v]][v];
      for (v = snk_node; v != src_node; v = par[v]) begin
        back = resid[v][par[v]];
        resid[par[v]][v] = resid[par[v]][v] - f;
        resid[v][par[v]] = (back > 32'hFFFF_FFFF - f) ? 32'hFFFF_FFFF : back + f;
      end
      total = total + f;
      if (total > 41'hFF_FFFF_FFFF) total = 41'hFF_FFFF_FFFF;
    end
    return total[FLOW_W-1:0];
  endfunction

  task automatic expect_add(input logic [FLOW_W-1:0] val);
    flow_expect_q.insert(flow_expect_q.size(), val);
  endtask

  task automatic idle_gap();
    int g;
    g = quiet ? 0 : ($urandom_range(0, 9) < 7 ? 0 :
        ($urandom_range(0, 19) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 4)));
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_edge(input edge_row_t r);
    logic [FLOW_W-1:0] pred;
    in_valid <= 1'b1;
    in_from_node <= r.from_n;
    in_to_node <= r.to_n;
    in_edge_capacity <= r.cap;
    in_last_edge <= r.last;
    do @(posedge clk); while (!in_ready);
    items++;
    resid[r.from_n][r.to_n] = {1'b0, r.cap};
    if (r.last) begin
      pred = solve_flow();
      foreach (resid[i, j]) resid[i][j] = '0;
      graphs++;
      if (r.typed) begin
        expect_add(r.flow);
        typed_checks++;
      end else begin
        expect_add(pred);
      end
    end
    idle_gap();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SOURCE) src_node = val; else snk_node = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (flow_expect_q.size() != 0) @(posedge clk);
    repeat (CLEAR_CYC) @(posedge clk);
  endtask

  task automatic random_graph();
    int k, n, cap_sel;
    int nodes [16];
    edge_row_t r;
    k = $urandom_range(3, 12);
    n = $urandom_range(4, 40);
    nodes[0] = src_node;
    nodes[1] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : snk_node;
    for (int i = 2; i < k; i++) nodes[i] = $urandom_range(0, 63);
    for (int e = 0; e < n; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        r.from_n = IDX_W'($urandom_range(0, 63));
        r.to_n = IDX_W'($urandom_range(0, 63));
      end else begin
        r.from_n = IDX_W'(nodes[$urandom_range(0, k - 1)]);
        r.to_n = IDX_W'(nodes[$urandom_range(0, k - 1)]);
      end
      cap_sel = $urandom_range(0, 9);
      r.cap = cap_sel == 0 ? 31'd0 : cap_sel == 1 ? CAP_INF :
              cap_sel == 2 ? 31'($urandom) : 31'($urandom_range(1, 1000));
      r.last = (e == n - 1);
      r.typed = 1'b0;
      r.flow = '0;
      send_edge(r);
    end
  endtask

  edge_row_t directed [] = '{
    '{0, 1, CAP_INF, 1, 1, 40'h7FFF_FFFF},
    '{0, 1, 5, 0, 0, 0},
    '{0, 1, 9, 0, 0, 0},
    '{1, 1, 3, 1, 1, 40'd9},
    '{0, 2, CAP_INF, 0, 0, 0},
    '{2, 1, CAP_INF, 0, 0, 0},
    '{0, 3, CAP_INF, 0, 0, 0},
    '{3, 1, CAP_INF, 0, 0, 0},
    '{63, 62, 0, 1, 1, 40'hFFFF_FFFE},
    '{0, 1, 0, 1, 1, 40'd0},
    '{0, 63, 10, 0, 0, 0},
    '{63, 1, 7, 0, 0, 0},
    '{1, 0, 4, 1, 0, 0},
    '{0, 2, 6, 0, 0, 0},
    '{2, 3, 5, 0, 0, 0},
    '{3, 1, 9, 0, 0, 0},
    '{2, 1, 2, 1, 0, 0}
  };

  initial begin
    int phase_items;
    foreach (resid[i, j]) resid[i][j] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_edge(directed[i]);
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin write_reg(REG_SOURCE, 6'd63); write_reg(REG_SINK, 6'd0); end
        1: begin write_reg(REG_SOURCE, 6'd5); write_reg(REG_SINK, 6'd5); end
        3: begin write_reg(REG_SOURCE, 6'd0); write_reg(REG_SINK, 6'd63); end
        default: begin
          write_reg(REG_SOURCE, IDX_W'($urandom_range(0, 63)));
          write_reg(REG_SINK, IDX_W'($urandom_range(0, 63)));
        end
      endcase
      quiet = (ph == 3);
      hold_req = (ph == 2);
      phase_items = items;
      while (items - phase_items < 240) random_graph();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (flow_expect_q.size() != 0) @(posedge clk);
    repeat (CLEAR_CYC) @(posedge clk);
    $display("Covered %0d edges in %0d graphs, %0d with fixed expected flows.",
             items, graphs, typed_checks);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  int stall_left = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 20000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) < 3)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                                   : $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (flow_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected flow result %0d", out_max_flow);
      end else begin
        if (out_max_flow !== flow_expect_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("max_flow mismatch: expected %0d, got %0d",
                     flow_expect_q[0], out_max_flow);
        end
        void'(flow_expect_q.pop_front());
      end
    end
  end

  initial begin
    #300_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mfek_pkg.sv
hw/rtl/mfek_ram.sv
hw/rtl/max_flow_edmonds_karp_core.sv
test/tb.sv
